FILE: hdl/iphb_pkg.sv
// iphb_pkg: shared constants, register map and checksum fold for the
// ipv4/tcp probe header builder; depends on nothing

package iphb_pkg;

    localparam int unsigned HDR_BYTES   = 40;
    localparam int unsigned HDR_BITS    = HDR_BYTES * 8;
    localparam logic [5:0]  LAST_OFFSET = 6'(HDR_BYTES - 1);

    // fixed header contents
    localparam logic [7:0]  VER_IHL      = 8'h45;
    localparam logic [7:0]  IP_TOS       = 8'h00;
    localparam logic [15:0] TOTAL_LEN    = 16'd40;
    localparam logic [15:0] FRAG_DF      = 16'h4000;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [15:0] TCP_LEN      = 16'd20;
    localparam logic [7:0]  TCP_DOFF     = 8'h50;
    localparam logic [31:0] ACK_NUMBER   = 32'd0;
    localparam logic [15:0] URGENT_PTR   = 16'd0;

    localparam logic [7:0]  TTL_RESET    = 8'd64;
    localparam logic [15:0] WINDOW_RESET = 16'hFFFF;

    // register map, one word per register
    typedef enum logic [0:0] {
        REG_TTL    = 1'b0,
        REG_WINDOW = 1'b1
    } reg_index_t;

    // end-around carry fold of a 20-bit sum, then one's complement
    function automatic logic [15:0] fold_invert(input logic [19:0] acc);
        logic [16:0] first;
        logic [15:0] second;
        first  = {1'b0, acc[15:0]} + {13'd0, acc[19:16]};
        second = first[15:0] + {15'd0, first[16]};
        return ~second;
    endfunction

endpackage

FILE: hdl/ipv4_tcp_probe_header_builder.sv
// ipv4_tcp_probe_header_builder: top level, probe request in, 40 header bytes out
// depends on iphb_pkg

// Each accepted request yields one 40-byte IPv4 + TCP header, sent as 40 output
// transactions of one byte each in network byte order, byte_offset counting 0..39
// and last_byte high on offset 39. A request passes an input register, a stage
// holding partial checksum sums, then loads a 320-bit shift register that drains
// one byte per cycle while out_stall is low; the shifter limits the sustained
// request rate. The first byte is presented as soon as the header loads into
// the shift register.
// The next request is taken while the current header is still draining, and its
// header loads in the cycle the previous last byte is taken. TTL (byte address 0)
// and TCP window (byte address 4) are read live and are to be written only while
// the block holds no request.

module ipv4_tcp_probe_header_builder
(
    input  logic        clk,
    input  logic        rst_n,

    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] source_address,
    input  logic [31:0] dest_address,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic [7:0]  flag_byte,
    input  logic [15:0] ip_ident,
    input  logic [31:0] seq_number,

    // header byte channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  header_byte,
    output logic [5:0]  byte_offset,
    output logic        last_byte,

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [7:0]  ttl_reg;
    logic [15:0] window_reg;
    logic        cfg_write;
    iphb_pkg::reg_index_t cfg_sel;

    assign pready    = 1'b1;
    assign cfg_sel   = iphb_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg    <= iphb_pkg::TTL_RESET;
            window_reg <= iphb_pkg::WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                iphb_pkg::REG_TTL:    ttl_reg    <= pwdata[7:0];
                iphb_pkg::REG_WINDOW: window_reg <= pwdata[15:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            iphb_pkg::REG_TTL:    prdata = {24'd0, ttl_reg};
            iphb_pkg::REG_WINDOW: prdata = {16'd0, window_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // pipeline flow control
    // ---------------------------------------------------------------
    logic       v0_reg;     // input register holds a request
    logic       v1_reg;     // sum stage holds a request
    logic       busy_reg;   // shifter is draining a header
    logic [5:0] pos_reg;    // offset of the byte at the shifter head

    logic out_fire;
    logic shift_free;       // shifter can load this cycle
    logic load_shift;
    logic s1_free;
    logic move_s1;
    logic s0_free;
    logic in_fire;

    assign out_fire   = busy_reg && !out_stall;
    assign shift_free = !busy_reg || (out_fire && (pos_reg == iphb_pkg::LAST_OFFSET));
    assign load_shift = v1_reg && shift_free;
    assign s1_free    = !v1_reg || load_shift;
    assign move_s1    = v0_reg && s1_free;
    assign s0_free    = !v0_reg || move_s1;
    assign in_stall   = !s0_free;
    assign in_fire    = in_valid && !in_stall;

    // ---------------------------------------------------------------
    // stage 0: request capture
    // ---------------------------------------------------------------
    logic [31:0] src0_reg, dst0_reg, seq0_reg;
    logic [15:0] sport0_reg, dport0_reg, ident0_reg;
    logic [7:0]  flags0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (s0_free)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            src0_reg   <= source_address;
            dst0_reg   <= dest_address;
            sport0_reg <= source_port;
            dport0_reg <= dest_port;
            flags0_reg <= flag_byte;
            ident0_reg <= ip_ident;
            seq0_reg   <= seq_number;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: partial one's complement sums
    // ---------------------------------------------------------------
    logic [17:0] addr_sum_next, addr_sum_reg;   // shared by both checksums
    logic [17:0] ip_part_next, ip_part_reg;     // rest of the ip header words
    logic [18:0] tcp_part_next, tcp_part_reg;   // tcp header plus pseudo-header constants
    logic [31:0] src1_reg, dst1_reg, seq1_reg;
    logic [15:0] sport1_reg, dport1_reg, ident1_reg;
    logic [7:0]  flags1_reg;

    always_comb
    begin
        addr_sum_next = 18'(src0_reg[31:16]) + 18'(src0_reg[15:0])
                      + 18'(dst0_reg[31:16]) + 18'(dst0_reg[15:0]);
        // checksum field counts as zero
        ip_part_next  = 18'({iphb_pkg::VER_IHL, iphb_pkg::IP_TOS})
                      + 18'(iphb_pkg::TOTAL_LEN) + 18'(iphb_pkg::FRAG_DF)
                      + 18'(ident0_reg) + 18'({ttl_reg, iphb_pkg::PROTO_TCP});
        // pseudo-header zero/protocol word and tcp length, ack and urgent are zero
        tcp_part_next = 19'(sport0_reg) + 19'(dport0_reg)
                      + 19'(seq0_reg[31:16]) + 19'(seq0_reg[15:0])
                      + 19'({iphb_pkg::TCP_DOFF, flags0_reg}) + 19'(window_reg)
                      + 19'(iphb_pkg::PROTO_TCP) + 19'(iphb_pkg::TCP_LEN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (s1_free)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (move_s1)
        begin
            addr_sum_reg <= addr_sum_next;
            ip_part_reg  <= ip_part_next;
            tcp_part_reg <= tcp_part_next;
            src1_reg     <= src0_reg;
            dst1_reg     <= dst0_reg;
            sport1_reg   <= sport0_reg;
            dport1_reg   <= dport0_reg;
            flags1_reg   <= flags0_reg;
            ident1_reg   <= ident0_reg;
            seq1_reg     <= seq0_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: fold checksums, assemble header, drain byte by byte
    // ---------------------------------------------------------------
    logic [19:0] ip_acc, tcp_acc;
    logic [15:0] ip_csum, tcp_csum;
    logic [iphb_pkg::HDR_BITS-1:0] header;
    logic [iphb_pkg::HDR_BITS-1:0] shift_reg;

    always_comb
    begin
        ip_acc   = 20'(addr_sum_reg) + 20'(ip_part_reg);
        tcp_acc  = 20'(addr_sum_reg) + 20'(tcp_part_reg);
        ip_csum  = iphb_pkg::fold_invert(ip_acc);
        tcp_csum = iphb_pkg::fold_invert(tcp_acc);
        // byte 0 at the top, network order
        header = {iphb_pkg::VER_IHL, iphb_pkg::IP_TOS, iphb_pkg::TOTAL_LEN,
                  ident1_reg, iphb_pkg::FRAG_DF, ttl_reg, iphb_pkg::PROTO_TCP,
                  ip_csum, src1_reg, dst1_reg,
                  sport1_reg, dport1_reg, seq1_reg, iphb_pkg::ACK_NUMBER,
                  iphb_pkg::TCP_DOFF, flags1_reg, window_reg, tcp_csum,
                  iphb_pkg::URGENT_PTR};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= 6'd0;
        end
        else if (load_shift)
        begin
            busy_reg <= 1'b1;
            pos_reg  <= 6'd0;
        end
        else if (out_fire)
        begin
            // last byte taken with nothing waiting
            if (pos_reg == iphb_pkg::LAST_OFFSET)
            begin
                busy_reg <= 1'b0;
                pos_reg  <= 6'd0;
            end
            else
                pos_reg <= pos_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_shift)
            shift_reg <= header;
        else if (out_fire)
            shift_reg <= {shift_reg[iphb_pkg::HDR_BITS-9:0], 8'd0};
    end

    assign out_valid   = busy_reg;
    assign header_byte = shift_reg[iphb_pkg::HDR_BITS-1 -: 8];
    assign byte_offset = pos_reg;
    assign last_byte   = (pos_reg == iphb_pkg::LAST_OFFSET);

endmodule

FILE: hdl/iphb_checker.sv
// iphb_checker: port-level assertions for the header builder, bound to the top
// depends on iphb_pkg

module iphb_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] header_byte,
    input logic [5:0] byte_offset,
    input logic       last_byte
);

    logic out_fire;
    assign out_fire = out_valid && !out_stall;

    // offsets run without gaps inside one header
    a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !last_byte |=> out_valid && (byte_offset == $past(byte_offset) + 6'd1))
        else $error("byte offset did not advance by one");

    // last flag marks exactly the final offset
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_byte == (byte_offset == iphb_pkg::LAST_OFFSET)))
        else $error("last_byte disagrees with byte_offset");

    // a new header always starts at offset zero
    a_new_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && last_byte |=> !out_valid || (byte_offset == 6'd0))
        else $error("header did not restart at offset zero");

    // a stalled byte holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(header_byte) && $stable(byte_offset))
        else $error("stalled output changed");

endmodule

bind ipv4_tcp_probe_header_builder iphb_checker u_iphb_checker (.*);

FILE: tb/ipv4_tcp_probe_header_builder_tb.sv
// ipv4_tcp_probe_header_builder_tb: self-checking testbench for the probe header builder
// drives probe requests and register writes, predicts all 40 header bytes per probe
// depends on iphb_pkg and hdl/ipv4_tcp_probe_header_builder.sv
`timescale 1ns / 100ps

module ipv4_tcp_probe_header_builder_tb;

    // run timing
    localparam int  CLK_HALF_NS   = 5;
    localparam int  SETTLE_CYCLES = 12;        // idle time after the last queued byte
    localparam int  RANDOM_PHASES = 4;
    localparam int  PHASE_ITEMS   = 38;        // with the directed probes, about 170 in total
    // slowest run: ~6800 bytes each behind the longest receiver stall, plus sender gaps; x4
    localparam longint TIMEOUT_NS = 64'd12_000_000;

    // header constants, kept local so the prediction stands on its own
    localparam logic [7:0]  HB_VER_IHL   = 8'h45;
    localparam logic [15:0] HB_TOTAL_LEN = 16'd40;
    localparam logic [15:0] HB_DF_FLAG   = 16'h4000;
    localparam logic [7:0]  HB_PROTO     = 8'd6;
    localparam logic [15:0] HB_TCP_LEN   = 16'd20;
    localparam logic [7:0]  HB_DATA_OFF  = 8'h50;

    // one probe request
    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  flag_byte;
        logic [15:0] ip_ident;
        logic [31:0] seq_number;
    } probe_t;

    // one expected output transaction
    typedef struct packed {
        logic [7:0] header_byte;
        logic [5:0] byte_offset;
        logic       last_byte;
    } hdr_byte_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  flag_byte;
    logic [15:0] ip_ident;
    logic [31:0] seq_number;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  header_byte;
    logic [5:0]  byte_offset;
    logic        last_byte;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // testbench copy of the registers
    logic [7:0]  cur_ttl;
    logic [15:0] cur_window;

    // header bytes still to come, oldest first
    hdr_byte_t   pending_bytes[$];
    int          mismatch_count;
    bit          quiet;                        // no idling on either side while set

    ipv4_tcp_probe_header_builder dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .source_address (source_address),
        .dest_address   (dest_address),
        .source_port    (source_port),
        .dest_port      (dest_port),
        .flag_byte      (flag_byte),
        .ip_ident       (ip_ident),
        .seq_number     (seq_number),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .header_byte    (header_byte),
        .byte_offset    (byte_offset),
        .last_byte      (last_byte),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // hard stop in case the block hangs or drops bytes
    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL ipv4_tcp_probe_header_builder");
        $finish;
    end

    // idle length for either side: mostly none, some short, a few long
    function automatic int gap_len();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // rfc 1071 sum over the leading 16-bit words of a 320-bit vector, folded and inverted
    function automatic logic [15:0] ones_comp_csum(input logic [319:0] words,
                                                   input int count);
        logic [31:0] acc;
        acc = 32'd0;
        for (int i = 0; i < count; i++)
            acc += {16'd0, words[319 - 16*i -: 16]};
        while (acc[31:16] != 16'd0)
            acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        return ~acc[15:0];
    endfunction

    // full 40-byte header, byte 0 in the top bits
    function automatic logic [319:0] predict_header(input probe_t p, input logic [7:0] ttl,
                                                    input logic [15:0] window);
        logic [159:0] ip_hdr;
        logic [159:0] tcp_hdr;
        logic [95:0]  pseudo_hdr;
        logic [15:0]  ip_csum;
        logic [15:0]  tcp_csum;
        ip_hdr = {HB_VER_IHL, 8'h00, HB_TOTAL_LEN, p.ip_ident, HB_DF_FLAG, ttl, HB_PROTO,
                  16'h0000, p.source_address, p.dest_address};
        ip_csum = ones_comp_csum({ip_hdr, 160'd0}, 10);
        ip_hdr[79:64] = ip_csum;
        pseudo_hdr = {p.source_address, p.dest_address, 8'h00, HB_PROTO, HB_TCP_LEN};
        tcp_hdr = {p.source_port, p.dest_port, p.seq_number, 32'd0, HB_DATA_OFF,
                   p.flag_byte, window, 16'h0000, 16'h0000};
        tcp_csum = ones_comp_csum({pseudo_hdr, tcp_hdr, 64'd0}, 16);
        tcp_hdr[31:16] = tcp_csum;
        return {ip_hdr, tcp_hdr};
    endfunction

    function automatic probe_t random_probe();
        probe_t p;
        p.source_address = $urandom();
        p.dest_address   = $urandom();
        p.source_port    = 16'($urandom());
        p.dest_port      = 16'($urandom());
        p.flag_byte      = 8'($urandom());
        p.ip_ident       = 16'($urandom());
        p.seq_number     = $urandom();
        // now and then push the addresses to their extremes for heavy carries
        if ($urandom_range(0, 7) == 0)
            p.source_address = 32'hFFFF_FFFF;
        if ($urandom_range(0, 7) == 0)
            p.dest_address = 32'd0;
        return p;
    endfunction

    // send one probe; returns at the edge where it was accepted
    task automatic send_probe(input probe_t p);
        logic [319:0] hdr;
        hdr_byte_t    e;
        int           gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        source_address <= p.source_address;
        dest_address   <= p.dest_address;
        source_port    <= p.source_port;
        dest_port      <= p.dest_port;
        flag_byte      <= p.flag_byte;
        ip_ident       <= p.ip_ident;
        seq_number     <= p.seq_number;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        // accepted: queue the 40 bytes it must produce
        hdr = predict_header(p, cur_ttl, cur_window);
        for (int i = 0; i < 40; i++)
        begin
            e.header_byte = hdr[319 - 8*i -: 8];
            e.byte_offset = 6'(i);
            e.last_byte   = (i == 39);
            pending_bytes.push_back(e);
        end
    endtask

    // stop sending and wait until every queued byte has come out
    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle, access cycle, register written at the closing edge,
    // then a return to idle
    task automatic write_reg(input iphb_pkg::reg_index_t idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // apb read with a check of the returned word, then a return to idle
    task automatic check_reg(input iphb_pkg::reg_index_t idx, input logic [31:0] expected);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== expected)
        begin
            $error("prdata: expected %08h, got %08h", expected, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // reprogram both registers while idle; upper garbage bits must be dropped
    task automatic set_registers(input logic [31:0] ttl_word, input logic [31:0] window_word);
        drain_outputs();
        write_reg(iphb_pkg::REG_TTL, ttl_word);
        cur_ttl = ttl_word[7:0];
        write_reg(iphb_pkg::REG_WINDOW, window_word);
        cur_window = window_word[15:0];
        check_reg(iphb_pkg::REG_TTL, {24'd0, cur_ttl});
        check_reg(iphb_pkg::REG_WINDOW, {16'd0, cur_window});
    endtask

    // receiver stall pattern: random bursts with stall-free runs between
    initial
    begin
        int n;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            n = gap_len();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // check every accepted header byte against the oldest expectation
    always @(posedge clk)
    begin
        hdr_byte_t e;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected header byte %02h at offset %0d", header_byte, byte_offset);
                mismatch_count++;
            end
            else
            begin
                e = pending_bytes.pop_front();
                if (header_byte !== e.header_byte)
                begin
                    $error("header_byte: expected %02h, got %02h (offset %0d)",
                           e.header_byte, header_byte, e.byte_offset);
                    mismatch_count++;
                end
                if (byte_offset !== e.byte_offset)
                begin
                    $error("byte_offset: expected %0d, got %0d", e.byte_offset, byte_offset);
                    mismatch_count++;
                end
                if (last_byte !== e.last_byte)
                begin
                    $error("last_byte: expected %0b, got %0b (offset %0d)",
                           e.last_byte, last_byte, e.byte_offset);
                    mismatch_count++;
                end
            end
        end
    end

    // reset values of the registers: no write yet, extremes of the request fields
    task automatic test_reset_defaults();
        probe_t p;
        check_reg(iphb_pkg::REG_TTL, {24'd0, cur_ttl});
        check_reg(iphb_pkg::REG_WINDOW, {16'd0, cur_window});
        p = '0;
        send_probe(p);
        p = '1;
        send_probe(p);
    endtask

    // each tcp flag bit alone
    task automatic test_flag_bits();
        probe_t p;
        for (int b = 0; b < 8; b++)
        begin
            p = random_probe();
            p.flag_byte = 8'(1 << b);
            send_probe(p);
        end
    endtask

    // checksum folding corners, with the reset ttl of 64
    task automatic test_checksum_fold();
        probe_t p;
        // ip sum lands exactly on ffff, so the checksum is zero
        p = '0;
        p.ip_ident = 16'h3AD1;
        send_probe(p);
        // one more and the sum carries out of 16 bits
        p.ip_ident = 16'h3AD2;
        send_probe(p);
        // all-ones content: many carries to fold on both checksums
        p = '1;
        p.flag_byte = 8'h00;
        send_probe(p);
    endtask

    // register extremes, written with junk above the field widths
    task automatic test_register_extremes();
        set_registers(32'hFFFF_FF00, 32'hFFFF_0000);
        send_probe(random_probe());
        send_probe(random_probe());
        set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_probe(random_probe());
        send_probe(random_probe());
        set_registers(32'hA5A5_A501, 32'h0000_8001);
        send_probe(random_probe());
        send_probe(random_probe());
    endtask

    // random probes across several register settings
    task automatic test_random_traffic();
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_registers($urandom(), $urandom());
            // one phase back to back with no idling anywhere
            quiet = (ph == 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // sender holds off until the block has emptied
                if (ph == 2 && i == PHASE_ITEMS / 2)
                    drain_outputs();
                send_probe(random_probe());
            end
            quiet = 1'b0;
        end
    endtask

    // main sequence
    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        source_address <= 32'd0;
        dest_address   <= 32'd0;
        source_port    <= 16'd0;
        dest_port      <= 16'd0;
        flag_byte      <= 8'd0;
        ip_ident       <= 16'd0;
        seq_number     <= 32'd0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= 3'd0;
        pwdata         <= 32'd0;
        cur_ttl        = 8'd64;
        cur_window     = 16'hFFFF;
        mismatch_count = 0;
        quiet          = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_flag_bits();
        test_checksum_fold();
        test_register_extremes();
        test_random_traffic();

        drain_outputs();
        if (mismatch_count == 0)
            $display("PASS ipv4_tcp_probe_header_builder");
        else
            $display("FAIL ipv4_tcp_probe_header_builder");
        $finish;
    end

endmodule
